FILE: rtl/core/pwp_pkg.sv
package pwp_pkg;

  typedef struct packed {
    logic signed [31:0] setpoint;
    logic signed [31:0] measured;
    logic               automatic_req;
    logic               raise_button;
    logic               lower_button;
    logic signed [31:0] cascade_track;
  } in_t;

  typedef struct packed {
    logic [22:0] drive_percent;
    logic        heat_on;
    logic        cool_on;
  } out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_PMUL_WAIT,
    ST_ISTEP,
    ST_IDIV_WAIT,
    ST_DSTEP,
    ST_DMUL_WAIT,
    ST_DDIV_GO,
    ST_DDIV_WAIT,
    ST_SUM,
    ST_PER_GO,
    ST_PER_WAIT,
    ST_RAT_GO,
    ST_RAT_WAIT,
    ST_FLAGS,
    ST_DONE
  } state_t;

  localparam logic [2:0] CFG_GAIN       = 3'd0;
  localparam logic [2:0] CFG_INT_TIME   = 3'd1;
  localparam logic [2:0] CFG_DER_TIME   = 3'd2;
  localparam logic [2:0] CFG_ZONE_ABOVE = 3'd3;
  localparam logic [2:0] CFG_ZONE_BELOW = 3'd4;
  localparam logic [2:0] CFG_PERIOD     = 3'd5;
  localparam logic [2:0] CFG_RATIO      = 3'd6;
  localparam logic [2:0] CFG_MODE       = 3'd7;

  // Serial multiplier: multiplicand and multiplier widths.
  localparam int MUL_AW = 40;
  localparam int MUL_BW = 32;
  // Serial divider: dividend and divisor widths.
  localparam int DIV_NW = 48;
  localparam int DIV_DW = 35;

  localparam logic [22:0] Q_HUNDRED = 23'd6553600;
  localparam logic [22:0] Q_FIFTY   = 23'd3276800;
  localparam logic [22:0] Q_STEP    = 23'd6554;
  localparam logic [16:0] RATIO_ONE = 17'd65536;

endpackage

FILE: rtl/core/pwp_mul.sv
module pwp_mul (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       start,
  input  logic [pwp_pkg::MUL_AW-1:0]                 a,
  input  logic [pwp_pkg::MUL_BW-1:0]                 b,
  output logic                                       done,
  output logic [pwp_pkg::MUL_AW+pwp_pkg::MUL_BW-1:0] prod
);

  localparam int AW = pwp_pkg::MUL_AW;
  localparam int BW = pwp_pkg::MUL_BW;
  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0] hi;
  logic [BW-1:0] lo;
  logic [AW-1:0] mcand;
  logic [CW-1:0] count;
  logic          busy;
  logic [AW:0]   sum;

  // One multiplier bit per cycle, least significant first.
  assign sum  = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);
  assign prod = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        hi    <= '0;
        lo    <= b;
        mcand <= a;
        count <= CW'(BW);
        busy  <= 1'b1;
      end else if (busy) begin
        hi    <= sum[AW:1];
        lo    <= {sum[0], lo[BW-1:1]};
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/pwp_div.sv
module pwp_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pwp_pkg::DIV_NW-1:0] num,
  input  logic [pwp_pkg::DIV_DW-1:0] den,
  output logic                       done,
  output logic [pwp_pkg::DIV_NW-1:0] quo
);

  localparam int NW = pwp_pkg::DIV_NW;
  localparam int DW = pwp_pkg::DIV_DW;
  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [CW-1:0] count;
  logic          busy;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // Restoring division, one quotient bit per cycle. The dividend shifts
  // out of the top of quo while quotient bits shift in at the bottom.
  assign trial = {rem, quo[NW-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= '0;
        quo   <= num;
        dvs   <= den;
        count <= CW'(NW);
        busy  <= 1'b1;
      end else if (busy) begin
        rem   <= ge ? diff[DW-1:0] : trial[DW-1:0];
        quo   <= {quo[NW-2:0], ge};
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/pid_with_pulse_output.sv
// The first automatic tick only primes the controller; a manual or zone-limited item runs
// the pulse multiply, and a full automatic tick runs the P, I and D steps first; a
// cool-side item adds the ratio multiply and a zero derivative time skips the derivative
// steps. Throughput: one item at a time; the next item can be taken in the cycle after
// its result is registered, and a stalled result holds the block. Reset is synchronous
// and active high; all controller state clears to zero.
module pid_with_pulse_output #(
  parameter int MIN_PULSE = 131072
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  pwp_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output pwp_pkg::out_t  out_data,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [30:0]    cfg_data
);

  localparam logic [23:0] MP      = 24'(MIN_PULSE);
  localparam logic [23:0] HUND_MP = 24'(6553600 - MIN_PULSE);
  localparam logic [23:0] FIFTY_P = 24'(3276800 + MIN_PULSE);
  localparam logic signed [24:0] FIFTY_M = 25'(3276800 - MIN_PULSE);
  localparam logic signed [63:0] MAX32 = 64'sd2147483647;
  localparam logic signed [63:0] MIN32 = -64'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > MAX32) r = 32'sh7fffffff;
    else if (v < MIN32) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic signed [63:0] ext32(input logic signed [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  // Configuration registers.
  logic [30:0] gain, integral_time, derivative_time, zone_above, zone_below;
  logic [15:0] pulse_period;
  logic [16:0] cool_heat_ratio;
  logic [1:0]  mode_bits;

  // Controller state.
  logic [22:0]        drive;
  logic signed [31:0] isum, i_prev, fe, last_prop;
  logic               auto_primed;
  logic [15:0]        period_count;
  logic               heat_flag, cool_flag;

  // Item and working registers.
  logic signed [31:0] err, track, p, dd;
  logic               automatic_mode, raise, lower;
  logic signed [47:0] d;

  pwp_pkg::state_t state, state_next;

  logic mul_start, mul_done, div_start, div_done;
  logic [pwp_pkg::MUL_AW-1:0] mul_a;
  logic [pwp_pkg::MUL_BW-1:0] mul_b;
  logic [pwp_pkg::MUL_AW+pwp_pkg::MUL_BW-1:0] mul_prod;
  logic [pwp_pkg::DIV_NW-1:0] div_num, div_quo;
  logic [pwp_pkg::DIV_DW-1:0] div_den;

  logic in_acc, out_free;
  logic signed [32:0] diff_in, err_neg;
  logic signed [31:0] err_in, casc_v, p_new, dd_c, isum_inc, isum_p, fe_new;
  logic zone_zero, zone_full;
  logic signed [24:0] man1, man2;
  logic [22:0] man1c, man2c, casc_drive, pulse_x, y_drive;
  logic signed [63:0] sprod, sprod_sh, inc, y;
  logic prod_neg, q_neg, y_high, y_low;
  logic [34:0] ti10, td10;
  logic [16:0] ratio_sat, c_next;
  logic [15:0] cnt_new;
  logic [22:0] c100;
  logic [21:0] c50;
  logic [71:0] lhs_two, lhs_cool, lhs_heat;
  logic cool_branch, three_point;

  pwp_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  pwp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_acc      = in_valid && !in_stall;
  assign out_free    = !out_valid || !out_stall;
  assign three_point = mode_bits[0];
  assign cool_branch = three_point && (drive <= pwp_pkg::Q_FIFTY);

  // Error and limit checks.
  always_comb begin
    diff_in = {in_data.setpoint[31], in_data.setpoint}
            - {in_data.measured[31], in_data.measured};
    if (diff_in[32] != diff_in[31]) begin
      err_in = diff_in[32] ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      err_in = diff_in[31:0];
    end
    err_neg   = -{err[31], err};
    zone_zero = (err_neg >= $signed({2'b00, zone_above}));
    zone_full = ($signed({err[31], err}) >= $signed({2'b00, zone_below}));
  end

  // Manual stepping and bumpless preload.
  always_comb begin
    man1  = $signed({2'b00, drive}) + (raise ? $signed({2'b00, pwp_pkg::Q_STEP}) : 25'sd0);
    man1c = (man1 > $signed({2'b00, pwp_pkg::Q_HUNDRED})) ? pwp_pkg::Q_HUNDRED
                                                          : man1[22:0];
    man2  = $signed({2'b00, man1c}) - (lower ? $signed({2'b00, pwp_pkg::Q_STEP}) : 25'sd0);
    man2c = man2[24] ? 23'd0 : man2[22:0];
    casc_v = sat32(ext32(track) - ext32(last_prop));
    if (casc_v[31]) begin
      casc_drive = '0;
    end else if (casc_v > $signed({9'b0, pwp_pkg::Q_HUNDRED})) begin
      casc_drive = pwp_pkg::Q_HUNDRED;
    end else begin
      casc_drive = casc_v[22:0];
    end
  end

  // P, I and D arithmetic around the serial units.
  always_comb begin
    prod_neg = (state == pwp_pkg::ST_PMUL_WAIT) ? err[31] : dd[31];
    sprod    = prod_neg ? -$signed({1'b0, mul_prod[62:0]}) : $signed({1'b0, mul_prod[62:0]});
    sprod_sh = sprod >>> 16;
    p_new    = sat32(sprod_sh);
    q_neg    = (state == pwp_pkg::ST_IDIV_WAIT) ? p[31] : dd[31];
    inc      = q_neg ? -$signed({16'b0, div_quo}) : $signed({16'b0, div_quo});
    isum_inc = sat32(ext32(isum) + inc);
    isum_p   = sat32(ext32(isum) + ext32(p));
    fe_new   = sat32(ext32(fe) + inc);
    dd_c     = sat32(ext32(err) - ext32(fe));
    ti10     = {1'b0, integral_time, 3'b000} + {3'b000, integral_time, 1'b0};
    td10     = {1'b0, derivative_time, 3'b000} + {3'b000, derivative_time, 1'b0};
    y        = ext32(p) + ext32(isum) + {{16{d[47]}}, d};
    y_high   = (y >= $signed({41'b0, pwp_pkg::Q_HUNDRED}));
    y_low    = (y <= 64'sd0);
    y_drive  = y_high ? pwp_pkg::Q_HUNDRED : (y_low ? 23'd0 : y[22:0]);
  end

  // Pulse period counter and compare operands.
  always_comb begin
    c_next    = {1'b0, period_count} + 17'd1;
    cnt_new   = (c_next > {1'b0, pulse_period}) ? 16'd1 : c_next[15:0];
    ratio_sat = (cool_heat_ratio > pwp_pkg::RATIO_ONE) ? pwp_pkg::RATIO_ONE
                                                       : cool_heat_ratio;
    if (!three_point) begin
      pulse_x = drive;
    end else if (cool_branch) begin
      pulse_x = pwp_pkg::Q_FIFTY - drive;
    end else begin
      pulse_x = drive - pwp_pkg::Q_FIFTY;
    end
    c100     = 23'(period_count) * 23'd100;
    c50      = 22'(period_count) * 22'd50;
    lhs_two  = 72'({c100, 16'b0});
    lhs_cool = 72'({c50, 32'b0});
    lhs_heat = 72'({c50, 16'b0});
  end

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    case (state)
      pwp_pkg::ST_IDLE:      if (in_acc) state_next = pwp_pkg::ST_DECIDE;
      pwp_pkg::ST_DECIDE: begin
        if (!automatic_mode) state_next = pwp_pkg::ST_PER_GO;
        else if (!auto_primed) state_next = pwp_pkg::ST_DONE;
        else if (zone_zero || zone_full) state_next = pwp_pkg::ST_PER_GO;
        else state_next = pwp_pkg::ST_PMUL_WAIT;
      end
      pwp_pkg::ST_PMUL_WAIT: if (mul_done) state_next = pwp_pkg::ST_ISTEP;
      pwp_pkg::ST_ISTEP: begin
        state_next = (integral_time == '0) ? pwp_pkg::ST_DSTEP : pwp_pkg::ST_IDIV_WAIT;
      end
      pwp_pkg::ST_IDIV_WAIT: if (div_done) state_next = pwp_pkg::ST_DSTEP;
      pwp_pkg::ST_DSTEP: begin
        state_next = (derivative_time == '0) ? pwp_pkg::ST_SUM : pwp_pkg::ST_DMUL_WAIT;
      end
      pwp_pkg::ST_DMUL_WAIT: if (mul_done) state_next = pwp_pkg::ST_DDIV_GO;
      pwp_pkg::ST_DDIV_GO:   state_next = pwp_pkg::ST_DDIV_WAIT;
      pwp_pkg::ST_DDIV_WAIT: if (div_done) state_next = pwp_pkg::ST_SUM;
      pwp_pkg::ST_SUM:       state_next = pwp_pkg::ST_PER_GO;
      pwp_pkg::ST_PER_GO:    state_next = pwp_pkg::ST_PER_WAIT;
      pwp_pkg::ST_PER_WAIT: begin
        if (mul_done) state_next = cool_branch ? pwp_pkg::ST_RAT_GO : pwp_pkg::ST_FLAGS;
      end
      pwp_pkg::ST_RAT_GO:    state_next = pwp_pkg::ST_RAT_WAIT;
      pwp_pkg::ST_RAT_WAIT:  if (mul_done) state_next = pwp_pkg::ST_FLAGS;
      pwp_pkg::ST_FLAGS:     state_next = pwp_pkg::ST_DONE;
      pwp_pkg::ST_DONE:      if (out_free) state_next = pwp_pkg::ST_IDLE;
      default:               state_next = pwp_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: unit controls and operand selection.
  always_comb begin
    in_stall  = (state != pwp_pkg::ST_IDLE);
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      pwp_pkg::ST_DECIDE: begin
        mul_start = automatic_mode && auto_primed && !zone_zero && !zone_full;
        mul_a     = 40'(abs32(err));
        mul_b     = {1'b0, gain};
      end
      pwp_pkg::ST_ISTEP: begin
        div_start = (integral_time != '0);
        div_num   = {abs32(p), 16'b0};
        div_den   = ti10;
      end
      pwp_pkg::ST_DSTEP: begin
        mul_start = (derivative_time != '0);
        mul_a     = 40'(abs32(dd_c));
        mul_b     = {1'b0, gain};
      end
      pwp_pkg::ST_DDIV_GO: begin
        div_start = 1'b1;
        div_num   = {abs32(dd), 16'b0};
        div_den   = td10;
      end
      pwp_pkg::ST_PER_GO: begin
        mul_start = 1'b1;
        mul_a     = 40'(pulse_x);
        mul_b     = 32'(pulse_period);
      end
      pwp_pkg::ST_RAT_GO: begin
        mul_start = 1'b1;
        mul_a     = mul_prod[39:0];
        mul_b     = 32'(ratio_sat);
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pwp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain            <= 31'd65536;
      integral_time   <= 31'd65536;
      derivative_time <= '0;
      zone_above      <= 31'h7fffffff;
      zone_below      <= 31'h7fffffff;
      pulse_period    <= 16'd100;
      cool_heat_ratio <= 17'd65536;
      mode_bits       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pwp_pkg::CFG_GAIN:       gain            <= cfg_data;
        pwp_pkg::CFG_INT_TIME:   integral_time   <= cfg_data;
        pwp_pkg::CFG_DER_TIME:   derivative_time <= cfg_data;
        pwp_pkg::CFG_ZONE_ABOVE: zone_above      <= cfg_data;
        pwp_pkg::CFG_ZONE_BELOW: zone_below      <= cfg_data;
        pwp_pkg::CFG_PERIOD:     pulse_period    <= cfg_data[15:0];
        pwp_pkg::CFG_RATIO:      cool_heat_ratio <= cfg_data[16:0];
        pwp_pkg::CFG_MODE:       mode_bits       <= cfg_data[1:0];
        default:                 mode_bits       <= mode_bits;
      endcase
    end
  end

  // Item capture and working registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      err            <= err_in;
      automatic_mode <= in_data.automatic_req;
      raise          <= in_data.raise_button;
      lower          <= in_data.lower_button;
      track          <= in_data.cascade_track;
    end
    if (state == pwp_pkg::ST_PMUL_WAIT && mul_done) p <= p_new;
    if (state == pwp_pkg::ST_DSTEP) begin
      dd <= dd_c;
      d  <= '0;
    end
    if (state == pwp_pkg::ST_DMUL_WAIT && mul_done) d <= sprod_sh[47:0];
  end

  // Controller state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      drive        <= '0;
      isum         <= '0;
      i_prev       <= '0;
      fe           <= '0;
      last_prop    <= '0;
      auto_primed  <= 1'b0;
      period_count <= '0;
      heat_flag    <= 1'b0;
      cool_flag    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      case (state)
        pwp_pkg::ST_DECIDE: begin
          i_prev <= isum;
          if (!automatic_mode) begin
            auto_primed <= 1'b0;
            drive       <= man2c;
          end else if (!auto_primed) begin
            if (mode_bits[1]) begin
              isum  <= casc_v;
              drive <= casc_drive;
            end else begin
              isum <= $signed({9'b0, drive});
            end
            fe          <= err;
            auto_primed <= 1'b1;
          end else if (zone_zero) begin
            drive <= '0;
          end else if (zone_full) begin
            drive <= pwp_pkg::Q_HUNDRED;
          end
        end
        pwp_pkg::ST_ISTEP: begin
          last_prop <= p;
          if (integral_time == '0) isum <= isum_p;
        end
        pwp_pkg::ST_IDIV_WAIT: if (div_done) isum <= isum_inc;
        pwp_pkg::ST_DSTEP: if (derivative_time == '0) fe <= '0;
        pwp_pkg::ST_DDIV_WAIT: if (div_done) fe <= fe_new;
        pwp_pkg::ST_SUM: begin
          drive <= y_drive;
          // Anti-windup: a saturated drive undoes this tick's integration.
          if (y_high || y_low) isum <= i_prev;
        end
        pwp_pkg::ST_PER_GO: period_count <= cnt_new;
        pwp_pkg::ST_FLAGS: begin
          if (!three_point) begin
            if ({1'b0, drive} < MP) heat_flag <= 1'b0;
            else if ({1'b0, drive} > HUND_MP) heat_flag <= 1'b1;
            else heat_flag <= (lhs_two < mul_prod);
          end else if (cool_branch) begin
            if ($signed({2'b00, drive}) > FIFTY_M) cool_flag <= 1'b0;
            else if ({1'b0, drive} < MP) cool_flag <= 1'b1;
            else cool_flag <= (lhs_cool < mul_prod);
          end else begin
            if ({1'b0, drive} < FIFTY_P) heat_flag <= 1'b0;
            else if ({1'b0, drive} > HUND_MP) heat_flag <= 1'b1;
            else heat_flag <= (lhs_heat < mul_prod);
          end
        end
        default: begin
          auto_primed <= auto_primed;
        end
      endcase
      if (state == pwp_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == pwp_pkg::ST_DONE && out_free) begin
      out_data.drive_percent <= drive;
      out_data.heat_on       <= heat_flag;
      out_data.cool_on       <= cool_flag;
    end
  end

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    drive <= pwp_pkg::Q_HUNDRED)
    else $error("drive above full scale");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == pwp_pkg::ST_DONE)
    else $error("result shown without a finished item");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == pwp_pkg::ST_DECIDE)
    else $error("accepted item did not start");

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mul_start && div_start))
    else $error("both serial units started together");

endmodule
